### hdl/shkc_pkg.sv
package shkc_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int PEAK_IN_BITS  = SAMPLE_BITS + 3;
    localparam int GAIN_BITS     = 23;
    localparam int THRESH_BITS   = 24;
    localparam int SLOPE_BITS    = 17;
    localparam int GAIN_FRAC     = 16;
    localparam int KNEE_BITS     = SAMPLE_BITS + 5;
    localparam int PROD_BITS     = KNEE_BITS + GAIN_BITS;
    localparam int SCALED_BITS   = PROD_BITS - GAIN_FRAC;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;
    localparam int NUM_CHANNELS_DEFAULT = 2;

    localparam logic [1:0] MODE_PROCESS    = 2'd0;
    localparam logic [1:0] MODE_READ_CLEAR = 2'd1;
    localparam logic [1:0] MODE_PEAK_MAX   = 2'd2;
    localparam logic [1:0] MODE_CLEAR      = 2'd3;

    localparam logic [1:0] CHAN_ALL = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INPUT_GAIN  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOPE       = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_GAIN = 2'd3;

    localparam logic [GAIN_BITS-1:0]   INPUT_GAIN_RESET  = 23'd65536;
    localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET   = 24'd8388608;
    localparam logic [SLOPE_BITS-1:0]  SLOPE_RESET       = 17'd32768;
    localparam logic [GAIN_BITS-1:0]   OUTPUT_GAIN_RESET = 23'd65536;

    localparam logic [SAMPLE_BITS-1:0] POS_MAX     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] NEG_MAG_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic [1:0]                    mode;
        logic [1:0]                    channel;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [PEAK_IN_BITS-1:0]       in_peak;
        logic [SAMPLE_BITS-1:0]        out_peak;
    } out_item_t;

endpackage

### hdl/static_hard_knee_compressor_core.sv
// Stereo static hard-knee compressor. Every input transfer yields exactly one output
// transfer. A process-sample item (mode 0) runs all its steps before the next possible
// acceptance: one 29x23 multiplier is shared by the input gain, the slope and the output
// gain steps, each followed by a step that rounds the product (saturating it after the
// gain steps). Read-and-clear and clear items go straight to the finish step; the
// larger-input-peak query scans the channels in turn through a single peak compare.
// in_stall is high while an item is in work; held output stalls only the final step.
module static_hard_knee_compressor_core #(
    parameter int NUM_CHANNELS = shkc_pkg::NUM_CHANNELS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  shkc_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output shkc_pkg::out_item_t                   out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [shkc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [shkc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int S    = shkc_pkg::SAMPLE_BITS;
    localparam int PIN  = shkc_pkg::PEAK_IN_BITS;
    localparam int KW   = shkc_pkg::KNEE_BITS;
    localparam int GW   = shkc_pkg::GAIN_BITS;
    localparam int PW   = shkc_pkg::PROD_BITS;
    localparam int SW   = shkc_pkg::SCALED_BITS;
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_IN,
        S_SAT_IN,
        S_SUB,
        S_MUL_SLOPE,
        S_KNEE,
        S_MUL_OUT,
        S_SAT_OUT,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                               state_reg;
    logic [1:0]                           mode_reg;
    logic [1:0]                           chan_reg;
    logic                                 addr_reg;
    logic [IDX_W-1:0]                     idx_reg;
    logic [PIN-1:0]                       max_reg;
    logic [PIN-1:0]                       in_store_reg  [NUM_CHANNELS];
    logic [S-1:0]                         out_store_reg [NUM_CHANNELS];
    logic [GW-1:0]                        input_gain_reg;
    logic [shkc_pkg::THRESH_BITS-1:0]     threshold_reg;
    logic [shkc_pkg::SLOPE_BITS-1:0]      slope_reg;
    logic [GW-1:0]                        output_gain_reg;
    logic                                 out_valid_reg;
    shkc_pkg::out_item_t                  out_data_reg;
    shkc_pkg::out_item_t                  out_data_next;

    logic                                 neg_reg;
    logic [S-1:0]                         mag_reg;
    logic [PW-1:0]                        prod_reg;
    logic [PIN-1:0]                       m_in_reg;
    logic [PIN-1:0]                       diff_reg;
    logic                                 above_reg;
    logic [KW-1:0]                        knee_reg;
    logic [S-1:0]                         m_out_reg;

    logic [KW-1:0]                        mul_a;
    logic [GW-1:0]                        mul_b;
    logic [PW-1:0]                        mul_prod;
    logic [PW-1:0]                        round_sum;
    logic [SW-1:0]                        scaled;
    logic [PIN-1:0]                       m_in_next;
    logic [KW-1:0]                        knee_next;
    logic [S-1:0]                         out_limit;
    logic [S-1:0]                         m_out_next;
    logic [S-1:0]                         s_out;
    logic                                 accept;
    logic                                 result_free;
    logic                                 in_addr;

    assign accept      = in_valid && (state_reg == S_IDLE);
    assign result_free = !out_valid_reg || !out_stall;
    assign in_addr     = (in_data.channel < shkc_pkg::CHAN_ALL)
                         && (32'(in_data.channel) < NUM_CHANNELS);

    always_comb
    begin
        case (state_reg)
            S_MUL_IN:
            begin
                mul_a = KW'(mag_reg);
                mul_b = input_gain_reg;
            end
            S_MUL_SLOPE:
            begin
                mul_a = KW'(diff_reg);
                mul_b = GW'(slope_reg);
            end
            S_MUL_OUT:
            begin
                mul_a = knee_reg;
                mul_b = output_gain_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod  = PW'(mul_a) * PW'(mul_b);
    assign round_sum = prod_reg + (PW'(1) << (shkc_pkg::GAIN_FRAC - 1));
    assign scaled    = round_sum[PW-1:shkc_pkg::GAIN_FRAC];
    assign m_in_next = (|scaled[SW-1:PIN]) ? {PIN{1'b1}} : scaled[PIN-1:0];
    assign knee_next = above_reg ? (KW'(threshold_reg) + KW'(scaled)) : KW'(m_in_reg);
    assign out_limit = neg_reg ? shkc_pkg::NEG_MAG_MAX : shkc_pkg::POS_MAX;
    assign m_out_next = (scaled > SW'(out_limit)) ? out_limit : scaled[S-1:0];
    assign s_out     = neg_reg ? (~m_out_reg + 1'b1) : m_out_reg;

    always_comb
    begin
        out_data_next = '0;
        case (mode_reg)
            shkc_pkg::MODE_PROCESS:
            begin
                out_data_next.sample_out = $signed(s_out);
            end
            shkc_pkg::MODE_READ_CLEAR:
            begin
                if (addr_reg)
                begin
                    out_data_next.in_peak  = in_store_reg[idx_reg];
                    out_data_next.out_peak = out_store_reg[idx_reg];
                end
            end
            shkc_pkg::MODE_PEAK_MAX:
            begin
                out_data_next.in_peak = max_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_reg <= in_data.sample_in[S-1];
                    mag_reg <= in_data.sample_in[S-1] ? (~in_data.sample_in + 1'b1)
                                                      : in_data.sample_in;
                end
            end
            S_MUL_IN, S_MUL_SLOPE, S_MUL_OUT:
            begin
                prod_reg <= mul_prod;
            end
            S_SAT_IN:
            begin
                m_in_reg <= m_in_next;
            end
            S_SUB:
            begin
                above_reg <= m_in_reg > PIN'(threshold_reg);
                diff_reg  <= m_in_reg - PIN'(threshold_reg);
            end
            S_KNEE:
            begin
                knee_reg <= knee_next;
            end
            S_SAT_OUT:
            begin
                m_out_reg <= m_out_next;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= shkc_pkg::MODE_PROCESS;
            chan_reg        <= '0;
            addr_reg        <= 1'b0;
            idx_reg         <= '0;
            max_reg         <= '0;
            input_gain_reg  <= shkc_pkg::INPUT_GAIN_RESET;
            threshold_reg   <= shkc_pkg::THRESHOLD_RESET;
            slope_reg       <= shkc_pkg::SLOPE_RESET;
            output_gain_reg <= shkc_pkg::OUTPUT_GAIN_RESET;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                in_store_reg[i]  <= '0;
                out_store_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    shkc_pkg::CFG_INPUT_GAIN:  input_gain_reg  <= cfg_data[GW-1:0];
                    shkc_pkg::CFG_THRESHOLD:   threshold_reg   <= cfg_data[shkc_pkg::THRESH_BITS-1:0];
                    shkc_pkg::CFG_SLOPE:       slope_reg       <= cfg_data[shkc_pkg::SLOPE_BITS-1:0];
                    shkc_pkg::CFG_OUTPUT_GAIN: output_gain_reg <= cfg_data[GW-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == S_FINISH && result_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg <= in_data.mode;
                        chan_reg <= in_data.channel;
                        addr_reg <= in_addr;
                        max_reg  <= '0;
                        idx_reg  <= (in_data.mode == shkc_pkg::MODE_PEAK_MAX)
                                    ? '0 : IDX_W'(in_data.channel);
                        case (in_data.mode)
                            shkc_pkg::MODE_PROCESS:  state_reg <= S_MUL_IN;
                            shkc_pkg::MODE_PEAK_MAX: state_reg <= S_SCAN;
                            default:                 state_reg <= S_FINISH;
                        endcase
                    end
                end
                S_MUL_IN:    state_reg <= S_SAT_IN;
                S_SAT_IN:    state_reg <= S_SUB;
                S_SUB:       state_reg <= S_MUL_SLOPE;
                S_MUL_SLOPE: state_reg <= S_KNEE;
                S_KNEE:      state_reg <= S_MUL_OUT;
                S_MUL_OUT:   state_reg <= S_SAT_OUT;
                S_SAT_OUT:   state_reg <= S_FINISH;
                S_SCAN:
                begin
                    if (in_store_reg[idx_reg] > max_reg)
                    begin
                        max_reg <= in_store_reg[idx_reg];
                    end
                    if (idx_reg == IDX_W'(NUM_CHANNELS - 1))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_FINISH:
                begin
                    if (result_free)
                    begin
                        out_data_reg  <= out_data_next;
                        state_reg     <= S_IDLE;
                        case (mode_reg)
                            shkc_pkg::MODE_PROCESS:
                            begin
                                if (addr_reg)
                                begin
                                    if (m_in_reg > in_store_reg[idx_reg])
                                    begin
                                        in_store_reg[idx_reg] <= m_in_reg;
                                    end
                                    if (m_out_reg > out_store_reg[idx_reg])
                                    begin
                                        out_store_reg[idx_reg] <= m_out_reg;
                                    end
                                end
                            end
                            shkc_pkg::MODE_READ_CLEAR:
                            begin
                                if (addr_reg)
                                begin
                                    in_store_reg[idx_reg]  <= '0;
                                    out_store_reg[idx_reg] <= '0;
                                end
                            end
                            shkc_pkg::MODE_PEAK_MAX:
                            begin
                            end
                            default:
                            begin
                                if (chan_reg == shkc_pkg::CHAN_ALL)
                                begin
                                    for (int i = 0; i < NUM_CHANNELS; i++)
                                    begin
                                        in_store_reg[i]  <= '0;
                                        out_store_reg[i] <= '0;
                                    end
                                end
                                else if (addr_reg)
                                begin
                                    in_store_reg[idx_reg]  <= '0;
                                    out_store_reg[idx_reg] <= '0;
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FINISH))
        else $error("result issued outside finish step");

    a_out_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.out_peak <= shkc_pkg::NEG_MAG_MAX))
        else $error("output peak above full scale");

    a_scan_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (mode_reg == shkc_pkg::MODE_PEAK_MAX))
        else $error("peak scan in wrong mode");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid && out_stall) |=> (state_reg == S_FINISH))
        else $error("result overwritten while held");

endmodule
